// ===== design/mbiir_pkg.sv =====
// Package for the multiband fourth-order IIR cascade.
// Holds the sizes, the controller-to-datapath command and status structs.
// Depends on nothing.
`timescale 1ns / 1ps

package mbiir_pkg;

    localparam int NUM_BANDS         = 8;
    localparam int NUM_CHANNELS      = 8;
    localparam int SECTIONS          = 2;
    localparam int TAPS              = 4;
    localparam int SAMPLE_BITS       = 24;
    localparam int COEFS_PER_SECTION = 2 * TAPS + 1;
    localparam int COEF_COUNT        = NUM_BANDS * SECTIONS * COEFS_PER_SECTION;
    localparam int HIST_PER_SECTION  = 2 * TAPS;
    localparam int HIST_COUNT        = NUM_BANDS * NUM_CHANNELS * SECTIONS * HIST_PER_SECTION;

    localparam int BAND_W  = $clog2(NUM_BANDS);
    localparam int CHAN_W  = $clog2(NUM_CHANNELS);
    localparam int SEC_W   = $clog2(SECTIONS);
    localparam int TAP_W   = $clog2(HIST_PER_SECTION);
    localparam int STEP_W  = $clog2(COEFS_PER_SECTION);
    localparam int HADDR_W = $clog2(HIST_COUNT);
    localparam int CADDR_W = 8;
    localparam int ACC_W   = 72;

    // Input command codes.
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_BAND_ENABLE = 1'b0;
    localparam logic CFG_BAND_MASK   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load;
        logic               coef_wr;
        logic               clr_wr;
        logic [HADDR_W-1:0] clr_addr;
        logic               rd_en;
        logic [STEP_W-1:0]  step;
        logic [BAND_W-1:0]  band;
        logic [SEC_W-1:0]   sec;
        logic               finish;
        logic               wr_en;
        logic [TAP_W-1:0]   wr_k;
        logic               advance;
        logic               out_load;
    } mbiir_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              out_busy;
        logic [CHAN_W-1:0] chan;
    } mbiir_stat_t;

endpackage

// ===== design/mbiir_ctrl.sv =====
// Controller of the multiband IIR cascade: sequencer state machine and config registers.
// Depends on mbiir_pkg.
`timescale 1ns / 1ps

module mbiir_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [63:0]          cfg_data,
    input  mbiir_pkg::mbiir_stat_t stat,
    output mbiir_pkg::mbiir_cmd_t  cmd
);
    import mbiir_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_BAND, ST_MAC, ST_DRAIN, ST_FINISH, ST_WRITE, ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [HADDR_W-1:0]  clr_reg, clr_next;
    logic [BAND_W-1:0]   band_reg, band_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [TAP_W-1:0]    k_reg, k_next;
    logic                drain_reg, drain_next;
    logic [NUM_BANDS-1:0] en_reg;
    logic [63:0]         mask_reg;
    logic                applies;

    assign applies = en_reg[band_reg] & mask_reg[{band_reg, stat.chan}];
    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        band_next  = band_reg;
        sec_next   = sec_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        cmd          = '0;
        cmd.clr_addr = clr_reg;
        cmd.step     = step_reg;
        cmd.band     = band_reg;
        cmd.sec      = sec_reg;
        cmd.wr_k     = k_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == HADDR_W'(HIST_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_COEF) begin
                        cmd.coef_wr = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        band_next  = '0;
                        state_next = ST_BAND;
                    end
                end
            end
            ST_BAND: begin
                if (applies) begin
                    sec_next   = '0;
                    step_next  = '0;
                    state_next = ST_MAC;
                end else if (band_reg == BAND_W'(NUM_BANDS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    band_next = band_reg + 1'b1;
                end
            end
            ST_MAC: begin
                cmd.rd_en = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(COEFS_PER_SECTION - 1)) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                k_next     = '0;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.wr_en = 1'b1;
                k_next    = k_reg + 1'b1;
                if (k_reg == TAP_W'(HIST_PER_SECTION - 1)) begin
                    cmd.advance = 1'b1;
                    if (sec_reg != SEC_W'(SECTIONS - 1)) begin
                        sec_next   = sec_reg + 1'b1;
                        step_next  = '0;
                        state_next = ST_MAC;
                    end else if (band_reg == BAND_W'(NUM_BANDS - 1)) begin
                        state_next = ST_OUT;
                    end else begin
                        band_next  = band_reg + 1'b1;
                        state_next = ST_BAND;
                    end
                end
            end
            ST_OUT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            band_reg  <= '0;
            sec_reg   <= '0;
            step_reg  <= '0;
            k_reg     <= '0;
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            band_reg  <= band_next;
            sec_reg   <= sec_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= '0;
            mask_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BAND_ENABLE: en_reg   <= cfg_data[NUM_BANDS-1:0];
                CFG_BAND_MASK:   mask_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // No item is taken while the history is being cleared or a sample is in work.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR || state_reg == ST_MAC) |-> !s_ready)
        else $error("input ready while busy");
    // A section read sequence is always followed by the drain.
    a_mac_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC && step_reg == STEP_W'(COEFS_PER_SECTION - 1))
        |=> state_reg == ST_DRAIN)
        else $error("section sequence broken");
    // The writeback of a section only follows its finish step.
    a_write_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_WRITE) |-> $past(state_reg == ST_FINISH))
        else $error("writeback without finish");

endmodule

// ===== design/mbiir_dp.sv =====
// Datapath of the multiband IIR cascade: coefficient and history memories, shared MAC,
// rounding, saturation and the output register. Depends on mbiir_pkg.
`timescale 1ns / 1ps

module mbiir_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mbiir_pkg::mbiir_cmd_t  cmd,
    output mbiir_pkg::mbiir_stat_t stat,
    input  logic [2:0]           s_channel,
    input  logic signed [23:0]   s_sample_in,
    input  logic [7:0]           s_coef_index,
    input  logic signed [31:0]   s_coef_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_channel_out,
    output logic signed [23:0]   m_sample_out,
    output logic                 m_clipped
);
    import mbiir_pkg::*;

    logic signed [31:0]  coef_mem [COEF_COUNT];
    logic [COEF_COUNT-1:0] coef_vld_reg;
    logic signed [31:0]  hist_mem [HIST_COUNT];

    logic signed [31:0]  coef_rd_reg, hist_rd_reg;
    logic signed [31:0]  x_reg, y_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic                clip_reg;
    logic                s1_valid_reg, s2_valid_reg;
    logic [STEP_W-1:0]   s1_step_reg;
    logic                s2_neg_reg;
    logic signed [63:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]  hbuf_reg [HIST_PER_SECTION];
    logic                m_valid_reg;
    logic [2:0]          out_chan_reg;
    logic signed [23:0]  out_sample_reg;
    logic                out_clip_reg;

    logic [CADDR_W-1:0]  coef_addr;
    logic [HADDR_W-1:0]  hist_rd_addr, hist_wr_addr;
    logic signed [31:0]  hist_wr_data;
    logic signed [31:0]  opnd;
    logic signed [ACC_W-1:0] acc_round;
    logic signed [ACC_W-28:0] acc_shift;
    logic                acc_fits;
    logic signed [31:0]  y_sat;
    logic                y_clip;
    logic signed [23:0]  final_sat;
    logic                final_clip;
    logic [STEP_W-1:0]   hstep;
    logic [STEP_W-1:0]   s1_tap;

    // Addresses of the current section's coefficient and history words.
    assign coef_addr    = CADDR_W'({cmd.band, cmd.sec}) * CADDR_W'(COEFS_PER_SECTION)
                        + CADDR_W'(cmd.step);
    assign hstep        = cmd.step - 1'b1;
    assign hist_rd_addr = {cmd.band, chan_reg, cmd.sec, hstep[TAP_W-1:0]};
    assign s1_tap       = s1_step_reg - 1'b1;

    // Coefficient store; entries never written read as zero.
    always_ff @(posedge aclk) begin
        if (cmd.coef_wr && s_coef_index < CADDR_W'(COEF_COUNT)) begin
            coef_mem[s_coef_index] <= s_coef_value;
        end
        coef_rd_reg <= coef_vld_reg[coef_addr] ? coef_mem[coef_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg <= '0;
        end else if (cmd.coef_wr && s_coef_index < CADDR_W'(COEF_COUNT)) begin
            coef_vld_reg[s_coef_index] <= 1'b1;
        end
    end

    // History writeback: new input at tap 0, new output at tap 4, others shift by one.
    always_comb begin
        if (cmd.clr_wr) begin
            hist_wr_addr = cmd.clr_addr;
            hist_wr_data = '0;
        end else begin
            hist_wr_addr = {cmd.band, chan_reg, cmd.sec, cmd.wr_k};
            if (cmd.wr_k == '0) begin
                hist_wr_data = x_reg;
            end else if (cmd.wr_k == TAP_W'(TAPS)) begin
                hist_wr_data = y_reg;
            end else begin
                hist_wr_data = hbuf_reg[cmd.wr_k - 1'b1];
            end
        end
    end

    // History store.
    always_ff @(posedge aclk) begin
        if (cmd.clr_wr || cmd.wr_en) begin
            hist_mem[hist_wr_addr] <= hist_wr_data;
        end
        hist_rd_reg <= hist_mem[hist_rd_addr];
    end

    // Multiplier operand: the section input for b0, a history word otherwise.
    assign opnd = (s1_step_reg == '0) ? x_reg : hist_rd_reg;

    // MAC pipeline: read, multiply, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg;
        end
        s1_step_reg <= cmd.step;
        prod_reg    <= coef_rd_reg * opnd;
        s2_neg_reg  <= (s1_step_reg > STEP_W'(TAPS));
        if (s1_valid_reg && s1_step_reg != '0) begin
            hbuf_reg[s1_tap[TAP_W-1:0]] <= hist_rd_reg;
        end
        if (cmd.rd_en && cmd.step == '0) begin
            acc_reg <= '0;
        end else if (s2_valid_reg) begin
            acc_reg <= s2_neg_reg ? acc_reg - ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round to nearest and saturate the section output to 32 bits.
    always_comb begin
        acc_round = acc_reg + (ACC_W'(1) <<< 26);
        acc_shift = acc_round[ACC_W-1:27];
        acc_fits  = (acc_shift[ACC_W-28:31] == '0) || (acc_shift[ACC_W-28:31] == '1);
        y_clip    = !acc_fits;
        if (acc_fits) begin
            y_sat = acc_shift[31:0];
        end else if (acc_shift[ACC_W-28]) begin
            y_sat = 32'sh8000_0000;
        end else begin
            y_sat = 32'sh7FFF_FFFF;
        end
    end

    // Saturate the cascade output to the sample width.
    always_comb begin
        final_clip = 1'b0;
        final_sat  = x_reg[23:0];
        if (x_reg > 32'sd8388607) begin
            final_sat  = 24'sh7F_FFFF;
            final_clip = 1'b1;
        end else if (x_reg < -32'sd8388608) begin
            final_sat  = 24'sh80_0000;
            final_clip = 1'b1;
        end
    end

    // Running sample value and clip flag.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= 32'(s_sample_in);
            chan_reg <= s_channel;
            clip_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                y_reg    <= y_sat;
                clip_reg <= clip_reg | y_clip;
            end
            if (cmd.advance) begin
                x_reg <= y_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_chan_reg   <= chan_reg;
            out_sample_reg <= final_sat;
            out_clip_reg   <= clip_reg | final_clip;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = out_chan_reg;
    assign m_sample_out  = out_sample_reg;
    assign m_clipped     = out_clip_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;
    assign stat.chan     = chan_reg;

    // A waiting result is never overwritten.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("output overwritten");
    // Clearing and section writeback never share the write port.
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_wr && cmd.wr_en))
        else $error("history write conflict");
    // The section is finished only after the MAC pipeline has drained.
    a_finish_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !s1_valid_reg && !s2_valid_reg)
        else $error("finish with products in flight");

endmodule

// ===== design/multiband_fourth_order_iir_cascade.sv =====
// Multiband fourth-order IIR cascade (parametric equalizer datapath).
//
// Input channel s_*: valid/ready items. s_command selects a sample to filter or
// a coefficient write; a coefficient write gives no result. Output channel m_*:
// one filtered sample per sample item, with its channel and a clip flag.
// Configuration: cfg_wr_en/cfg_index/cfg_data write band_enable (0) or
// band_channel_mask (1); the user must write only while idle, the block does not check.
// Sequencing: one shared 32x32 MAC serves every section. Each section runs 9 MAC
// issues, a pipeline drain, a rounding step and 8 history writebacks, in that order.
// A sample holds the input through its acceptance, one check per band, the two
// sections of each applied band and the output load of its result. A coefficient
// write is taken while the block is idle and returns to idle.
// After reset all 1024 history words are cleared, one word a cycle, while s_ready
// stays low. A result waits in the output register while m_ready is low; the next
// item is accepted meanwhile and holds only at its own result.
// Depends on mbiir_pkg, mbiir_ctrl and mbiir_dp.
`timescale 1ns / 1ps

module multiband_fourth_order_iir_cascade (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [2:0]          s_channel,
    input  logic signed [23:0]  s_sample_in,
    input  logic [7:0]          s_coef_index,
    input  logic signed [31:0]  s_coef_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_channel_out,
    output logic signed [23:0]  m_sample_out,
    output logic                m_clipped,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data
);
    import mbiir_pkg::*;

    mbiir_cmd_t  cmd;
    mbiir_stat_t stat;

    // Sequencer and configuration registers.
    mbiir_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Memories, MAC and output register.
    mbiir_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_channel     (s_channel),
        .s_sample_in   (s_sample_in),
        .s_coef_index  (s_coef_index),
        .s_coef_value  (s_coef_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_sample_out  (m_sample_out),
        .m_clipped     (m_clipped)
    );

endmodule
